### rtl/dwc_pkg.sv
// dwc_pkg: shared types and constants for the depthwise dilated 3x3 convolution
// no dependencies
package dwc_pkg;

  localparam int KSIZE = 3;
  localparam int NTAPS = 9;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_RATE   = 2'd2;
  localparam logic [1:0] CFG_PLANES = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ACC,
    ST_EMIT,
    ST_NEXT
  } state_t;

  // one output position handed from the sequencer to the datapath
  typedef struct packed {
    logic [11:0] row;
    logic [7:0]  col;
    logic [7:0]  plane;
    logic        last;
  } pos_t;

  // read command toward the line store
  typedef struct packed {
    logic        en;
    logic [3:0]  tap;
    logic        in_img;
  } rd_cmd_t;

endpackage

### rtl/depthwise_dilated_conv3x3.sv
// depthwise_dilated_conv3x3: top level with sequencer, line store and tap accumulator
// depends on dwc_pkg, dwc_line_store, dwc_mac
//
//   channel  direction  handshake       payload
//   input    in         valid / stall   kind, tap, value
//   output   out        out_valid/stall out_row, out_col, out_plane, result, last
//   config   in         cfg_valid/ready cfg_index, cfg_data
//
// a weight load is written straight into the weights; a pixel takes each output it
// releases through nine line store reads through the one read port, the multiply
// and accumulate stages and the output register, and passes through ST_NEXT once
// more for each row of outputs it walks
// a pixel releases up to (MAX_RATE+1)^2 outputs at the corner of a plane
// rst is synchronous; the line store is not cleared, out of image taps are masked
// stall on the output holds the result register and the sequencer
module depthwise_dilated_conv3x3 import dwc_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_RATE   = 4,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [3:0]  tap,
  input  logic [15:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_row,
  output logic [7:0]  out_col,
  output logic [7:0]  out_plane,
  output logic [35:0] result,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SLOTS = 2 * MAX_RATE + 1;
  localparam int WB    = $clog2(MAX_WIDTH);
  localparam int SB    = $clog2(SLOTS);
  localparam int DEPTH = SLOTS * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int RB    = $clog2(MAX_RATE + 1);
  localparam int HB    = $clog2(MAX_HEIGHT + 1);
  localparam int WCB   = $clog2(MAX_WIDTH + 1);

  // config registers
  logic [8:0]  width;
  logic [12:0] height;
  logic [2:0]  rate;
  logic [8:0]  plane_count;

  // effective values, signed arithmetic below on 18 bit ints
  logic [WCB-1:0] eff_w;
  logic [HB-1:0]  eff_h;
  logic [RB-1:0]  eff_r;
  logic [8:0]     eff_p;

  always_comb begin
    if (width == 9'd0) eff_w = WCB'(1);
    else if (32'(width) > MAX_WIDTH) eff_w = WCB'(MAX_WIDTH);
    else eff_w = WCB'(width);
    if (height == 13'd0) eff_h = HB'(1);
    else if (32'(height) > MAX_HEIGHT) eff_h = HB'(MAX_HEIGHT);
    else eff_h = HB'(height);
    if (32'(rate) > MAX_RATE) eff_r = RB'(MAX_RATE);
    else eff_r = RB'(rate);
    if (plane_count == 9'd0) eff_p = 9'd1;
    else if (plane_count > 9'd256) eff_p = 9'd256;
    else eff_p = plane_count;
  end

  // stream position and slot of the current row
  logic [11:0]   pixel_row;
  logic [7:0]    pixel_col;
  logic [7:0]    plane_index;
  logic [SB-1:0] row_slot;

  // kernel weights
  logic [15:0] weights [NTAPS];

  // sequencer
  state_t state, state_next;
  logic signed [17:0] h_cur, x_cur, hhi, xlo, xhi;
  logic [3:0] tcnt;   // tap being read
  logic [3:0] wait_cnt;
  pos_t cur_pos;

  logic in_acc;
  assign in_stall = (state != ST_IDLE) | (out_valid & out_stall);
  assign in_acc   = in_valid & ~in_stall;
  assign cfg_ready = (state == ST_IDLE);

  // signed views
  logic signed [17:0] r_s, c_s, R_s, W1, H1;
  assign r_s = 18'(pixel_row);
  assign c_s = 18'(pixel_col);
  assign R_s = 18'(eff_r);
  assign W1  = 18'(eff_w) - 18'sd1;
  assign H1  = 18'(eff_h) - 18'sd1;

  // tap coordinates and their slot
  logic signed [17:0] ih, iw, kh_off, kw_off;
  logic [3:0] kh_i, kw_i;
  logic tap_in;
  logic [SB-1:0] tap_slot;
  logic [AW-1:0] raddr, waddr;
  logic signed [17:0] dh;
  always_comb begin
    kh_i = (tcnt >= 4'd6) ? 4'd2 : ((tcnt >= 4'd3) ? 4'd1 : 4'd0);
    kw_i = tcnt - 4'(kh_i * 4'd3);
    kh_off = (18'(kh_i) - 18'sd1) * R_s;
    kw_off = (18'(kw_i) - 18'sd1) * R_s;
    ih = h_cur + kh_off;
    iw = x_cur + kw_off;
    tap_in = (ih >= 0) && (ih <= H1) && (iw >= 0) && (iw <= W1);
    // ring slot of ih, relative to the slot of the current row (ih <= r)
    dh = r_s - ih;
    if (18'(row_slot) >= dh) tap_slot = SB'(18'(row_slot) - dh);
    else tap_slot = SB'(18'(row_slot) + 18'(SLOTS) - dh);
    raddr = AW'(32'(tap_slot) * MAX_WIDTH + 32'(iw[WB-1:0]));
    waddr = AW'(32'(row_slot) * MAX_WIDTH + 32'(pixel_col));
  end

  logic [15:0] rd_pix;
  dwc_line_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk(clk), .we(in_acc & kind), .waddr(waddr), .wdata(value),
    .re(state == ST_READ), .raddr(raddr), .rdata(rd_pix)
  );

  // taps in flight line up with the read data
  rd_cmd_t cmd_d;
  always_ff @(posedge clk) begin
    if (rst) cmd_d <= '0;
    else begin
      cmd_d.en     <= (state == ST_READ);
      cmd_d.tap    <= tcnt;
      cmd_d.in_img <= tap_in;
    end
  end

  logic signed [35:0] acc;
  dwc_mac u_mac (
    .clk(clk), .clear(state == ST_IDLE || state == ST_NEXT), .valid(cmd_d.en),
    .in_img(cmd_d.in_img), .pix(rd_pix), .wgt(weights[cmd_d.tap]), .acc(acc)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_acc && kind) state_next = ST_NEXT;
      ST_NEXT: begin
        if (h_cur > hhi) state_next = ST_IDLE;
        else if (x_cur > xhi) state_next = ST_NEXT;
        else state_next = ST_READ;
      end
      ST_READ: if (tcnt == 4'(NTAPS - 1)) state_next = ST_ACC;
      ST_ACC:  if (wait_cnt == 4'd2) state_next = ST_EMIT;
      ST_EMIT: if (!(out_valid && out_stall)) state_next = ST_NEXT;
      default: state_next = ST_IDLE;
    endcase
  end

  // position bookkeeping
  logic signed [17:0] lo_h, lo_x;
  always_comb begin
    lo_h = (r_s - R_s < 0) ? 18'sd0 : r_s - R_s;
    lo_x = (c_s - R_s < 0) ? 18'sd0 : c_s - R_s;
    cur_pos.row   = h_cur[11:0];
    cur_pos.col   = x_cur[7:0];
    cur_pos.plane = plane_index;
    cur_pos.last  = (9'(plane_index) == eff_p - 9'd1) && (h_cur == H1) && (x_cur == W1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      width <= 9'd256; height <= 13'd256; rate <= 3'd4; plane_count <= 9'd1;
      pixel_row <= '0; pixel_col <= '0; plane_index <= '0; row_slot <= '0;
      out_valid <= 1'b0;
      tcnt <= '0; wait_cnt <= '0;
      h_cur <= '0; x_cur <= '0; hhi <= '0; xlo <= '0; xhi <= '0;
    end else begin
      state <= state_next;
      // output valid set on emit, cleared when taken
      if (state == ST_EMIT && !(out_valid && out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      // configuration write also rewinds the stream
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_WIDTH:  width <= cfg_data[8:0];
          CFG_HEIGHT: height <= cfg_data[12:0];
          CFG_RATE:   rate <= cfg_data[2:0];
          CFG_PLANES: plane_count <= cfg_data[8:0];
          default: ;
        endcase
        pixel_row <= '0; pixel_col <= '0; plane_index <= '0; row_slot <= '0;
      end
      unique case (state)
        ST_IDLE: if (in_acc && kind) begin
          h_cur <= lo_h;
          x_cur <= lo_x;
          xlo   <= lo_x;
          hhi   <= (r_s == H1) ? r_s : r_s - R_s;
          xhi   <= (c_s == W1) ? c_s : c_s - R_s;
          tcnt  <= '0;
        end
        ST_NEXT: begin
          tcnt <= '0;
          if (h_cur > hhi) begin
            // advance stream position after the last output
            if (18'(pixel_col) + 18'sd1 >= 18'(eff_w)) begin
              pixel_col <= '0;
              if (18'(pixel_row) + 18'sd1 >= 18'(eff_h)) begin
                pixel_row <= '0;
                row_slot <= '0;
                plane_index <= (9'(plane_index) + 9'd1 >= eff_p) ? '0 : plane_index + 8'd1;
              end else begin
                pixel_row <= pixel_row + 12'd1;
                row_slot <= (row_slot == SB'(SLOTS - 1)) ? '0 : row_slot + SB'(1);
              end
            end else begin
              pixel_col <= pixel_col + 8'd1;
            end
          end else if (x_cur > xhi) begin
            x_cur <= xlo;
            h_cur <= h_cur + 18'sd1;
          end
        end
        ST_READ: begin
          tcnt <= tcnt + 4'd1;
          wait_cnt <= '0;
        end
        ST_ACC: wait_cnt <= wait_cnt + 4'd1;
        ST_EMIT: if (!(out_valid && out_stall)) begin
          x_cur <= x_cur + 18'sd1;
        end
        default: ;
      endcase
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (state == ST_EMIT && !(out_valid && out_stall)) begin
      out_row   <= cur_pos.row;
      out_col   <= cur_pos.col;
      out_plane <= cur_pos.plane;
      last      <= cur_pos.last;
      result    <= acc;
    end
  end

  // weight loads
  always_ff @(posedge clk) begin
    if (in_acc && !kind && tap < 4'(NTAPS)) begin
      weights[tap] <= value;
    end
  end

  ap_no_input_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("input taken while busy");
  ap_emit_after_acc: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> ($past(state) == ST_ACC || $past(state) == ST_EMIT))
    else $error("emit without accumulation");
  ap_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> (state == ST_IDLE)) else $error("config accepted while busy");

endmodule

### rtl/dwc_line_store.sv
// dwc_line_store: ring of row slots holding recent pixel rows
// depends on nothing beyond its parameters
module dwc_line_store #(
  parameter int DEPTH = 2304,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/dwc_mac.sv
// dwc_mac: one tap product per cycle accumulated into the full precision sum
// depends on dwc_pkg
module dwc_mac import dwc_pkg::*; (
  input  logic               clk,
  input  logic               clear,
  input  logic               valid,
  input  logic               in_img,
  input  logic signed [15:0] pix,
  input  logic signed [15:0] wgt,
  output logic signed [35:0] acc
);

  logic signed [31:0] prod;
  logic               prod_v;

  // multiply stage, then accumulate stage
  always_ff @(posedge clk) begin
    prod   <= pix * wgt;
    prod_v <= valid & in_img;
    if (clear) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + 36'(prod);
    end
  end

endmodule
